// ----- src/i2cme_pkg.sv -----
package i2cme_pkg;

   // Width of the quarter-period divider counter.
   localparam int DIVIDER_WIDTH = 16;
   localparam int QUARTER_WIDTH = 16;
   localparam int CMP_WIDTH     = (DIVIDER_WIDTH > QUARTER_WIDTH) ? DIVIDER_WIDTH
                                                                  : QUARTER_WIDTH;
   localparam int STEP_WIDTH    = 6;
   localparam int KIND_WIDTH    = 3;

   localparam logic [QUARTER_WIDTH-1:0] QUARTER_RESET = QUARTER_WIDTH'(250);

   // Command codes; the idle code doubles as the clock tick request kind.
   localparam logic [KIND_WIDTH-1:0] CMD_IDLE  = 3'd0;
   localparam logic [KIND_WIDTH-1:0] CMD_START = 3'd1;
   localparam logic [KIND_WIDTH-1:0] CMD_STOP  = 3'd2;
   localparam logic [KIND_WIDTH-1:0] CMD_WRITE = 3'd3;
   localparam logic [KIND_WIDTH-1:0] CMD_READ  = 3'd4;
   localparam logic [KIND_WIDTH-1:0] CMD_ADDR  = 3'd5;

   // Number of quarter-period steps in each command.
   localparam logic [STEP_WIDTH-1:0] STEPS_START = 6'd3;
   localparam logic [STEP_WIDTH-1:0] STEPS_STOP  = 6'd3;
   localparam logic [STEP_WIDTH-1:0] STEPS_WRITE = 6'd28;
   localparam logic [STEP_WIDTH-1:0] STEPS_READ  = 6'd19;
   localparam logic [STEP_WIDTH-1:0] STEPS_ADDR  = 6'd31;

   typedef struct packed {
      logic                  sda_pin;
      logic                  master_ack;
      logic                  read_flag;
      logic [7:0]            data_byte;
      logic [KIND_WIDTH-1:0] kind;
   } item_type;

   typedef struct packed {
      logic       rejected;
      logic       slave_acked;
      logic [7:0] read_value;
      logic       done_res;
      logic       busy_res;
      logic       sda_pull_low;
      logic       scl_pull_low;
   } result_type;

endpackage

// ----- src/i2cme_core.sv -----
module i2cme_core import i2cme_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     step_en,
   input  item_type                 item,
   input  logic [QUARTER_WIDTH-1:0] quarter_cycles,
   output result_type               result
);

   typedef struct packed {
      logic       scl;
      logic       sda;
      logic [7:0] shift;
      logic       ack_flag;
      logic       ack_to_send;
   } pins_type;

   localparam logic [DIVIDER_WIDTH-1:0] DIV_MAX = {DIVIDER_WIDTH{1'b1}};

   logic [KIND_WIDTH-1:0]    active_ff, active_in;
   logic [STEP_WIDTH-1:0]    step_ff, step_in;
   logic [DIVIDER_WIDTH-1:0] div_ff, div_in;
   pins_type                 pins_ff, pins_in;
   logic [7:0]               last_read_ff, last_read_in;

   logic                     is_cmd;
   logic                     busy;
   logic                     expire;
   logic                     done;
   logic                     rejected;
   logic [DIVIDER_WIDTH-1:0] div_next;
   logic [STEP_WIDTH-1:0]    step_next;
   pins_type                 loaded;

   // Remainder by three of a six-bit value: 4 is 1 mod 3, so fold base-4 digits.
   function automatic logic [1:0] rem3(input logic [STEP_WIDTH-1:0] g);
      logic [3:0] s;
      logic [2:0] t;
      s = {2'b00, g[5:4]} + {2'b00, g[3:2]} + {2'b00, g[1:0]};
      t = {1'b0, s[3:2]} + {1'b0, s[1:0]};
      rem3 = (t >= 3'd3) ? 2'(t - 3'd3) : t[1:0];
   endfunction

   function automatic logic [STEP_WIDTH-1:0] steps_of(input logic [KIND_WIDTH-1:0] cmd);
      logic [STEP_WIDTH-1:0] n;
      unique case (cmd)
         CMD_START: n = STEPS_START;
         CMD_STOP:  n = STEPS_STOP;
         CMD_WRITE: n = STEPS_WRITE;
         CMD_READ:  n = STEPS_READ;
         CMD_ADDR:  n = STEPS_ADDR;
         default:   n = '0;
      endcase
      return n;
   endfunction

   function automatic pins_type start_step(input logic [STEP_WIDTH-1:0] g,
                                           input pins_type cur);
      pins_type p;
      p = cur;
      if (g == 6'd0) p.sda = 1'b0;
      else if (g == 6'd1) p.scl = 1'b0;
      else p.sda = 1'b1;
      return p;
   endfunction

   function automatic pins_type stop_step(input logic [STEP_WIDTH-1:0] g,
                                          input pins_type cur);
      pins_type p;
      p = cur;
      if (g == 6'd0) p.sda = 1'b1;
      else if (g == 6'd1) p.scl = 1'b0;
      else p.sda = 1'b0;
      return p;
   endfunction

   function automatic pins_type write_step(input logic [STEP_WIDTH-1:0] g,
                                           input logic sda_in,
                                           input pins_type cur);
      pins_type   p;
      logic [1:0] r;
      p = cur;
      r = rem3(g);
      if (g < 6'd24) begin
         if (r == 2'd0) begin
            p.scl = 1'b1;
         end else if (r == 2'd1) begin
            p.sda   = ~cur.shift[7];
            p.shift = {cur.shift[6:0], 1'b0};
         end else begin
            p.scl = 1'b0;
         end
      end else if (g == 6'd24) begin
         p.scl = 1'b1;
      end else if (g == 6'd25) begin
         p.sda = 1'b0;
      end else if (g == 6'd26) begin
         p.scl      = 1'b0;
         p.ack_flag = ~sda_in;
      end else begin
         p.scl = 1'b1;
      end
      return p;
   endfunction

   function automatic pins_type read_step(input logic [STEP_WIDTH-1:0] g,
                                          input logic sda_in,
                                          input pins_type cur);
      pins_type p;
      p = cur;
      if (g < 6'd16) begin
         if (!g[0]) begin
            p.scl = 1'b1;
            p.sda = 1'b0;
         end else begin
            p.scl   = 1'b0;
            p.shift = {cur.shift[6:0], sda_in};
         end
      end else if (g == 6'd16) begin
         p.scl = 1'b1;
         p.sda = cur.ack_to_send;
      end else if (g == 6'd17) begin
         p.scl = 1'b0;
      end else begin
         p.scl = 1'b1;
         p.sda = 1'b0;
      end
      return p;
   endfunction

   function automatic pins_type apply_step(input logic [KIND_WIDTH-1:0] cmd,
                                           input logic [STEP_WIDTH-1:0] g,
                                           input logic sda_in,
                                           input pins_type cur);
      pins_type p;
      unique case (cmd)
         CMD_START: p = start_step(g, cur);
         CMD_STOP:  p = stop_step(g, cur);
         CMD_WRITE: p = write_step(g, sda_in, cur);
         CMD_READ:  p = read_step(g, sda_in, cur);
         CMD_ADDR:  p = (g < 6'd3) ? start_step(g, cur)
                                   : write_step(g - 6'd3, sda_in, cur);
         default:   p = cur;
      endcase
      return p;
   endfunction

   always_comb begin
      is_cmd    = (item.kind >= CMD_START) && (item.kind <= CMD_ADDR);
      busy      = (active_ff != CMD_IDLE);
      div_next  = div_ff + 1'b1;
      expire    = (CMP_WIDTH'(div_next) >= CMP_WIDTH'(quarter_cycles))
                  || (div_next == DIV_MAX) || (div_next == '0);
      step_next = step_ff + 1'b1;

      active_in    = active_ff;
      step_in      = step_ff;
      div_in       = div_ff;
      pins_in      = pins_ff;
      last_read_in = last_read_ff;
      done         = 1'b0;
      rejected     = 1'b0;

      loaded = pins_ff;
      unique case (item.kind)
         CMD_WRITE: loaded.shift = item.data_byte;
         CMD_ADDR:  loaded.shift = item.data_byte | {7'b0, item.read_flag};
         CMD_READ: begin
            loaded.shift       = '0;
            loaded.ack_to_send = item.master_ack;
         end
         default: ;
      endcase

      if (is_cmd) begin
         if (busy) begin
            rejected = 1'b1;
         end else begin
            active_in = item.kind;
            step_in   = '0;
            div_in    = '0;
            pins_in   = apply_step(item.kind, '0, item.sda_pin, loaded);
         end
      end else if (busy) begin
         if (expire) begin
            div_in = '0;
            if (step_next >= steps_of(active_ff)) begin
               if (active_ff == CMD_READ) last_read_in = pins_ff.shift;
               active_in = CMD_IDLE;
               step_in   = '0;
               done      = 1'b1;
            end else begin
               step_in = step_next;
               pins_in = apply_step(active_ff, step_next, item.sda_pin, pins_ff);
            end
         end else begin
            div_in = div_next;
         end
      end

      result.scl_pull_low = pins_in.scl;
      result.sda_pull_low = pins_in.sda;
      result.busy_res     = (active_in != CMD_IDLE);
      result.done_res     = done;
      result.read_value   = last_read_in;
      result.slave_acked  = pins_in.ack_flag;
      result.rejected     = rejected;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff    <= CMD_IDLE;
         step_ff      <= '0;
         div_ff       <= '0;
         pins_ff      <= '0;
         last_read_ff <= '0;
      end else if (step_en) begin
         active_ff    <= active_in;
         step_ff      <= step_in;
         div_ff       <= div_in;
         pins_ff      <= pins_in;
         last_read_ff <= last_read_in;
      end
   end

endmodule

// ----- src/i2c_master_byte_engine_unit.sv -----
// Channel   Direction  Handshake              Contents
// req_      in         req_tvalid/req_tready  kind in tuser, command operands in tdata
// rsp_      out        rsp_tvalid/rsp_tready  pin drives, status, read byte, ACK
// csr_      in         csr_valid/csr_ready    quarter period in clock ticks
//
// Every request yields exactly one response, passing through the request register
// and then the response register. One request is taken per clock cycle when the
// response side is not stalled; the throughput is set by the single combinational
// step between the request register and the response register. A stalled response
// holds both registers and back-pressures the request side. Reset is synchronous
// and returns the engine to idle with the quarter period at 250 ticks.
module i2c_master_byte_engine_unit import i2cme_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_tvalid,
   output logic                     req_tready,
   // [7:0] data_byte, [8] read_flag, [9] master_ack, [10] sda_pin, rest zero
   input  logic [15:0]              req_tdata,
   // [2:0] kind
   input  logic [KIND_WIDTH-1:0]    req_tuser,
   output logic                     rsp_tvalid,
   input  logic                     rsp_tready,
   // [0] scl_pull_low, [1] sda_pull_low, [2] busy_res, [3] done_res,
   // [11:4] read_value, [12] slave_acked, [13] rejected, rest zero
   output logic [15:0]              rsp_tdata,
   input  logic                     csr_valid,
   output logic                     csr_ready,
   input  logic [QUARTER_WIDTH-1:0] csr_wdata
);

   logic                     req_valid_ff;
   item_type                 item_ff;
   logic                     rsp_valid_ff;
   result_type               result_ff;
   logic [QUARTER_WIDTH-1:0] quarter_ff;
   result_type               result_in;
   logic                     advance;

   // A held request moves on whenever the response register is free or emptying.
   assign advance    = req_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !req_valid_ff || advance;
   assign csr_ready  = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
      end else if (req_tready) begin
         req_valid_ff <= req_tvalid;
      end
   end

   // The request register carries payload only and so needs no reset.
   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         item_ff.kind       <= req_tuser;
         item_ff.data_byte  <= req_tdata[7:0];
         item_ff.read_flag  <= req_tdata[8];
         item_ff.master_ack <= req_tdata[9];
         item_ff.sda_pin    <= req_tdata[10];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         quarter_ff <= QUARTER_RESET;
      end else if (csr_valid) begin
         quarter_ff <= csr_wdata;
      end
   end

   // The engine state advances exactly once per request, as it moves to the response.
   i2cme_core u_core (
      .clock          (clock),
      .reset          (reset),
      .step_en        (advance),
      .item           (item_ff),
      .quarter_cycles (quarter_ff),
      .result         (result_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         result_ff <= result_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {2'b00, result_ff};

endmodule
